// ----- rtl/rsfl_pkg.sv -----
// rsfl_pkg: shared constants, codes and types of the record slot allocator
// no dependencies; compiled first
`timescale 1ns / 1ps

package rsfl_pkg;

  // id layout: page number above a byte offset within the page
  localparam int ID_W         = 18;
  localparam int PAGE_BYTES   = 8192;
  localparam int FOOTER_BYTES = 64;
  localparam int OFF_W        = $clog2(PAGE_BYTES);
  localparam int PAGE_W       = ID_W - OFF_W;
  localparam int ROOM_BYTES   = (PAGE_BYTES > FOOTER_BYTES) ? (PAGE_BYTES - FOOTER_BYTES) : 0;

  // record size register
  localparam int CFG_W      = 13;
  localparam int MIN_STRIDE = 8;

  // offset divider: quotient bits retired per cycle
  localparam int DIV_STEPS = 4;
  localparam int DIV_CYC   = (OFF_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_LEN   = DIV_CYC * DIV_STEPS;

  // depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FORMAT,
    B_READ,
    B_EXEC
  } back_state_t;

  // classified operation handed from front to back
  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [OFF_W-1:0] idx;
    logic             shape_ok;
  } entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic avail;
    logic full;
  } qstat_t;

endpackage

// ----- rtl/rsfl_if.sv -----
// rsfl_if: valid/ready channel interfaces for command, response and config
// depends on rsfl_pkg for field widths
`timescale 1ns / 1ps

interface rsfl_cmd_if;
  import rsfl_pkg::*;
  logic            valid;
  logic            ready;
  logic [1:0]      operation;
  logic [ID_W-1:0] record_id;
  modport source (output valid, output operation, output record_id, input ready);
  modport sink (input valid, input operation, input record_id, output ready);
endinterface

interface rsfl_rsp_if;
  import rsfl_pkg::*;
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] granted_id;
  logic            occupied;
  logic [1:0]      status;
  modport source (output valid, output granted_id, output occupied, output status, input ready);
  modport sink (input valid, input granted_id, input occupied, input status, output ready);
endinterface

interface rsfl_cfg_if;
  import rsfl_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/rsfl_front.sv -----
// rsfl_front: accepts command beats, divides the offset by the stride for free
// and query, and classifies the id; depends on rsfl_pkg and rsfl_if
`timescale 1ns / 1ps

module rsfl_front #(
  parameter int SLOTS_PER_PAGE = 512
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [rsfl_pkg::CFG_W-1:0] stride,
  rsfl_cmd_if.sink                cmd,
  output logic                    push,
  output rsfl_pkg::entry_t        push_entry,
  input  rsfl_pkg::qstat_t        qstat
);
  import rsfl_pkg::*;

  localparam int CNT_W = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  front_state_t       state, state_next;
  op_t                op;
  logic [ID_W-1:0]    id;
  logic [DIV_LEN-1:0] dvd, dvd_next;
  logic [DIV_LEN-1:0] quot, quot_next;
  logic [OFF_W-1:0]   rem, rem_next;
  logic [CNT_W-1:0]   cnt;
  logic               accept;
  logic               div_last;
  logic [PAGE_W-1:0]  page;
  logic [OFF_W:0]     reach;
  logic               fits;
  logic               aligned;
  logic               idx_ok;

  assign accept   = cmd.valid && cmd.ready;
  assign div_last = (cnt == CNT_W'(DIV_CYC - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          if (op_t'(cmd.operation) == OP_FREE || op_t'(cmd.operation) == OP_QUERY) begin
            state_next = F_DIV;
          end else begin
            state_next = F_PUSH;
          end
        end
      end
      F_DIV: begin
        if (div_last) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!qstat.full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    cmd.ready = (state == F_IDLE);
    push      = (state == F_PUSH) && !qstat.full;
  end

  // restoring divider, several quotient bits per cycle
  always_comb begin
    logic [OFF_W:0]     trial;
    logic [DIV_LEN-1:0] d;
    logic [DIV_LEN-1:0] q;
    logic [OFF_W-1:0]   r;
    d     = dvd;
    q     = quot;
    r     = rem;
    trial = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {r, d[DIV_LEN-1]};
      d     = {d[DIV_LEN-2:0], 1'b0};
      if (trial >= (OFF_W+1)'(stride)) begin
        trial = trial - (OFF_W+1)'(stride);
        q     = {q[DIV_LEN-2:0], 1'b1};
      end else begin
        q     = {q[DIV_LEN-2:0], 1'b0};
      end
      r = trial[OFF_W-1:0];
    end
    dvd_next  = d;
    quot_next = q;
    rem_next  = r;
  end

  // state and operand registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if (state == F_DIV) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= op_t'(cmd.operation);
      id   <= cmd.record_id;
      dvd  <= DIV_LEN'(cmd.record_id[OFF_W-1:0]);
      quot <= '0;
      rem  <= '0;
    end else if (state == F_DIV) begin
      dvd  <= dvd_next;
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

  // slot shape checks: data page, stride alignment, slot fits before footer, index in range
  always_comb begin
    page    = id[ID_W-1:OFF_W];
    reach   = {1'b0, id[OFF_W-1:0]} + (OFF_W+1)'(stride);
    fits    = (reach <= (OFF_W+1)'(ROOM_BYTES));
    aligned = (rem == '0);
    idx_ok  = (quot < DIV_LEN'(SLOTS_PER_PAGE));
    push_entry.op       = op;
    push_entry.id       = id;
    push_entry.idx      = quot[OFF_W-1:0];
    push_entry.shape_ok = (page != '0) && aligned && fits && idx_ok;
  end

endmodule

// ----- rtl/rsfl_queue.sv -----
// rsfl_queue: short queue of classified operations between front and back
// depends on rsfl_pkg
`timescale 1ns / 1ps

module rsfl_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rsfl_pkg::entry_t push_entry,
  input  logic             pop,
  output rsfl_pkg::entry_t head,
  output rsfl_pkg::qstat_t qstat
);
  import rsfl_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  entry_t           store [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // status and head entry
  always_comb begin
    qstat.avail = (count != '0);
    qstat.full  = (count == CNT_W'(Q_DEPTH));
    head        = store[rd_ptr];
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- rtl/rsfl_back.sv -----
// rsfl_back: free list head, page formatting sweep, link and occupancy
// memories and response register; depends on rsfl_pkg and rsfl_if
`timescale 1ns / 1ps

module rsfl_back #(
  parameter int SLOTS_PER_PAGE = 512,
  parameter int DATA_PAGES     = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rsfl_pkg::CFG_W-1:0] stride,
  input  rsfl_pkg::entry_t           head,
  input  rsfl_pkg::qstat_t           qstat,
  output logic                       pop,
  rsfl_rsp_if.source                 rsp
);
  import rsfl_pkg::*;

  localparam int TOTAL  = SLOTS_PER_PAGE * DATA_PAGES;
  localparam int SLOT_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int SW_W   = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;
  localparam int PF_W   = $clog2(DATA_PAGES + 1);
  localparam int LINK_W = ID_W + SLOT_W;

  back_state_t       state, state_next;

  // free list and page state
  logic [ID_W-1:0]   head_id;
  logic [SLOT_W-1:0] head_slot;
  logic              list_empty;
  logic [PF_W-1:0]   pages;

  // operation in progress
  op_t               work_op;
  logic [ID_W-1:0]   work_id;
  logic [SLOT_W-1:0] work_slot;

  // formatting sweep
  logic [SW_W-1:0]   sw_cnt;
  logic [SLOT_W-1:0] sw_slot;
  logic [OFF_W:0]    sw_off;

  // memories
  logic [LINK_W-1:0] link_mem [TOTAL];
  logic              occ_mem  [TOTAL];
  logic [LINK_W-1:0] link_rd;
  logic              occ_rd;

  // response register
  logic              out_valid;
  logic [ID_W-1:0]   res_granted;
  logic              res_occ;
  status_t           res_status;

  // decode helpers
  logic              take;
  logic [PAGE_W-1:0] head_page;
  logic              page_ok;
  logic [SLOT_W-1:0] take_slot;
  logic              pages_full;
  logic              no_room;
  logic              sw_fits;
  logic              sw_last;
  logic [SLOT_W-1:0] rd_slot;
  logic [LINK_W-1:0] link_head_val;
  logic [ID_W-1:0]   next_link_id;

  // strobes from the output block
  logic              finish;
  logic [ID_W-1:0]   fin_granted;
  logic              fin_occ;
  status_t           fin_status;
  logic              occ_we;
  logic [SLOT_W-1:0] occ_waddr;
  logic              occ_wdata;
  logic              link_we;
  logic [SLOT_W-1:0] link_waddr;
  logic [LINK_W-1:0] link_wdata;
  logic              head_we;
  logic [ID_W-1:0]   head_id_new;
  logic [SLOT_W-1:0] head_slot_new;
  logic              empty_new;

  always_comb begin
    take          = (state == B_IDLE) && qstat.avail && !out_valid;
    head_page     = head.id[ID_W-1:OFF_W];
    page_ok       = head.shape_ok && (int'(head_page) <= int'(pages));
    take_slot     = SLOT_W'((int'(head_page) - 1) * SLOTS_PER_PAGE + int'(head.idx));
    pages_full    = (int'(pages) >= DATA_PAGES);
    no_room       = (int'(stride) > ROOM_BYTES);
    sw_fits       = ((sw_off + (OFF_W+1)'(stride)) <= (OFF_W+1)'(ROOM_BYTES));
    sw_last       = (sw_cnt == SW_W'(SLOTS_PER_PAGE - 1));
    rd_slot       = (work_op == OP_ALLOC) ? head_slot : work_slot;
    link_head_val = list_empty ? '0 : {head_id, head_slot};
    next_link_id  = link_rd[LINK_W-1:SLOT_W];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (take) begin
          case (head.op)
            OP_ALLOC: begin
              if (!list_empty) begin
                state_next = B_READ;
              end else if (!(pages_full || no_room)) begin
                state_next = B_FORMAT;
              end
            end
            OP_FREE, OP_QUERY: begin
              if (page_ok) begin
                state_next = B_READ;
              end
            end
            default: state_next = B_IDLE;
          endcase
        end
      end
      B_FORMAT: begin
        if (sw_last) begin
          state_next = B_READ;
        end
      end
      B_READ:  state_next = B_EXEC;
      B_EXEC:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // control strobes and result values
  always_comb begin
    pop           = take;
    finish        = 1'b0;
    fin_granted   = '0;
    fin_occ       = 1'b0;
    fin_status    = ST_OK;
    occ_we        = 1'b0;
    occ_waddr     = rd_slot;
    occ_wdata     = 1'b0;
    link_we       = 1'b0;
    link_waddr    = work_slot;
    link_wdata    = link_head_val;
    head_we       = 1'b0;
    head_id_new   = head_id;
    head_slot_new = head_slot;
    empty_new     = list_empty;
    case (state)
      B_IDLE: begin
        if (take) begin
          case (head.op)
            OP_ALLOC: begin
              if (list_empty && (pages_full || no_room)) begin
                finish     = 1'b1;
                fin_status = ST_FULL;
              end
            end
            OP_FREE, OP_QUERY: begin
              if (!page_ok) begin
                finish     = 1'b1;
                fin_status = ST_RANGE;
              end
            end
            default: finish = 1'b1;
          endcase
        end
      end
      B_FORMAT: begin
        // clear every occupancy bit of the page, link the slots that fit
        occ_we    = 1'b1;
        occ_waddr = sw_slot;
        occ_wdata = 1'b0;
        if (sw_fits) begin
          link_we       = 1'b1;
          link_waddr    = sw_slot;
          head_we       = 1'b1;
          head_id_new   = {PAGE_W'(pages + PF_W'(1)), sw_off[OFF_W-1:0]};
          head_slot_new = sw_slot;
          empty_new     = 1'b0;
        end
      end
      B_EXEC: begin
        finish = 1'b1;
        case (work_op)
          OP_ALLOC: begin
            fin_granted   = head_id;
            fin_occ       = ~occ_rd;
            occ_we        = 1'b1;
            occ_wdata     = ~occ_rd;
            head_we       = 1'b1;
            head_id_new   = next_link_id;
            head_slot_new = link_rd[SLOT_W-1:0];
            empty_new     = (next_link_id == '0);
          end
          OP_FREE: begin
            fin_occ       = ~occ_rd;
            occ_we        = 1'b1;
            occ_wdata     = ~occ_rd;
            link_we       = 1'b1;
            head_we       = 1'b1;
            head_id_new   = work_id;
            head_slot_new = work_slot;
            empty_new     = 1'b0;
          end
          OP_QUERY: begin
            fin_occ = occ_rd;
          end
          default: fin_occ = 1'b0;
        endcase
      end
      default: finish = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      head_id    <= '0;
      head_slot  <= '0;
      list_empty <= 1'b1;
      pages      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (head_we) begin
        head_id    <= head_id_new;
        head_slot  <= head_slot_new;
        list_empty <= empty_new;
      end
      if (state == B_FORMAT && sw_last) begin
        pages <= pages + PF_W'(1);
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // work, sweep and result registers
  always_ff @(posedge clk) begin
    if (take) begin
      work_op   <= head.op;
      work_id   <= head.id;
      work_slot <= take_slot;
      sw_cnt    <= '0;
      sw_off    <= '0;
      sw_slot   <= SLOT_W'(int'(pages) * SLOTS_PER_PAGE);
    end else if (state == B_FORMAT) begin
      sw_cnt  <= sw_cnt + SW_W'(1);
      sw_slot <= sw_slot + SLOT_W'(1);
      if (sw_fits) begin
        sw_off <= sw_off + (OFF_W+1)'(stride);
      end
    end
    if (finish) begin
      res_granted <= fin_granted;
      res_occ     <= fin_occ;
      res_status  <= fin_status;
    end
  end

  // link memory
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd <= link_mem[rd_slot];
  end

  // occupancy memory
  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    occ_rd <= occ_mem[rd_slot];
  end

  assign rsp.valid      = out_valid;
  assign rsp.granted_id = res_granted;
  assign rsp.occupied   = res_occ;
  assign rsp.status     = res_status;

endmodule

// ----- rtl/record_slot_free_list_allocator_top.sv -----
// Record slot allocator over paged storage.
// Channels: cmd carries operation (allocate, free, query) and record_id;
// rsp returns granted_id, occupied and status, one beat per command beat,
// in order; cfg writes record_bytes (slot stride, values below 8 act as 8).
// The user must write cfg only while the block is idle; the block itself
// does not enforce this.
// Free and query pass the id offset through the divider in the front; an
// allocate that finds the list empty first formats a page, sweeping its
// SLOTS_PER_PAGE slots.
// The front takes no new command while it divides or waits to push, and
// the back takes no new entry while it formats, reads or writes back the
// link and occupancy memories, or while its response waits.
// The front keeps accepting commands into a two-entry queue while a
// response waits; when rsp stalls, the back holds its response register and
// the queue fills until cmd ready drops.
// Reset: free list empty, no page formatted, stride 8; the memories are not
// cleared, a page's occupancy bits are cleared when it is formatted.
// depends on rsfl_pkg, rsfl_if, rsfl_front, rsfl_queue, rsfl_back
`timescale 1ns / 1ps

module record_slot_free_list_allocator_top #(
  parameter int SLOTS_PER_PAGE = 512,
  parameter int DATA_PAGES     = 16
) (
  input  logic       clk,
  input  logic       rst,
  rsfl_cmd_if.sink   cmd,
  rsfl_rsp_if.source rsp,
  rsfl_cfg_if.sink   cfg
);
  import rsfl_pkg::*;

  logic [CFG_W-1:0] stride;
  logic             push;
  entry_t           push_entry;
  logic             pop;
  entry_t           q_head;
  qstat_t           qstat;

  // stride register, clamped to the minimum slot size
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride <= CFG_W'(MIN_STRIDE);
    end else if (cfg.valid && cfg.ready) begin
      stride <= (cfg.data < CFG_W'(MIN_STRIDE)) ? CFG_W'(MIN_STRIDE) : cfg.data;
    end
  end

  rsfl_front #(
    .SLOTS_PER_PAGE (SLOTS_PER_PAGE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .stride     (stride),
    .cmd        (cmd),
    .push       (push),
    .push_entry (push_entry),
    .qstat      (qstat)
  );

  rsfl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (q_head),
    .qstat      (qstat)
  );

  rsfl_back #(
    .SLOTS_PER_PAGE (SLOTS_PER_PAGE),
    .DATA_PAGES     (DATA_PAGES)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .stride (stride),
    .head   (q_head),
    .qstat  (qstat),
    .pop    (pop),
    .rsp    (rsp)
  );

endmodule

// ----- rtl/rsfl_checker.sv -----
// rsfl_checker: port-level assertions on the allocator response channel
// depends on rsfl_pkg; bound to record_slot_free_list_allocator_top
`timescale 1ns / 1ps

module rsfl_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [rsfl_pkg::ID_W-1:0] rsp_granted_id,
  input logic                      rsp_occupied,
  input logic [1:0]                rsp_status
);
  import rsfl_pkg::*;

  // no response beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_id)
      && $stable(rsp_occupied) && $stable(rsp_status))
    else $error("stalled response changed");

  // only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_FULL || rsp_status == ST_RANGE))
    else $error("undefined status code");

  // failed operations grant nothing and report a clear bit
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_granted_id == '0 && !rsp_occupied)
    else $error("error response carries data");

  // a granted id always lies in a data page
  a_grant_page: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_granted_id != '0 |-> rsp_granted_id[ID_W-1:OFF_W] != '0)
    else $error("granted id in header page");

endmodule

bind record_slot_free_list_allocator_top rsfl_checker u_rsfl_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_granted_id (rsp.granted_id),
  .rsp_occupied   (rsp.occupied),
  .rsp_status     (rsp.status)
);
